FILE: hdl/udd_pkg.sv
// Shared widths and pipeline depths for the unit direction and distance block.
// No dependencies; used by every module under hdl/.
`default_nettype none

package udd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;     // signed B - A
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;     // |B - A| up to 2^24
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH - 1;   // square up to 2^48
    localparam int SUM_WIDTH   = SQ_WIDTH + 1;        // three squares
    localparam int DIST_WIDTH  = SUM_WIDTH / 2;       // root bits
    localparam int SQ_STAGES   = DIST_WIDTH;          // one root bit per stage
    localparam int SQ_REM_W    = DIST_WIDTH + 1;
    localparam int UNIT_WIDTH  = 16;
    localparam int UNIT_FRAC   = 15;
    localparam int DIV_STAGES  = UNIT_FRAC + 1;       // quotient 0..2^15
    localparam int DIV_REM_W   = DIST_WIDTH + 1;
    localparam int NUM_LANES   = 3;

    // front stages: difference, squares, sum
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQ_STAGES + DIV_STAGES;
    localparam int SQ_LAST      = FRONT_STAGES + SQ_STAGES - 1;

    localparam logic [UNIT_WIDTH-1:0] UNIT_MAX = 16'h7FFF;

    typedef struct packed {
        logic [NUM_LANES-1:0]                neg;
        logic                                use_z;
        logic [NUM_LANES-1:0][MAG_WIDTH-1:0] mag;
    } side_t;

endpackage

`default_nettype wire

FILE: hdl/udd_sqrt.sv
// Pipelined integer square root, one root bit per stage (digit by digit).
// Depends on udd_pkg.
`default_nettype none

module udd_sqrt (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic [udd_pkg::SUM_WIDTH-1:0]      rad_in,
    output logic      [udd_pkg::DIST_WIDTH-1:0]     root_out
);

    logic [udd_pkg::SQ_STAGES-1:0][udd_pkg::SUM_WIDTH-1:0]  rad_reg,  rad_next;
    logic [udd_pkg::SQ_STAGES-1:0][udd_pkg::SQ_REM_W-1:0]   rem_reg,  rem_next;
    logic [udd_pkg::SQ_STAGES-1:0][udd_pkg::DIST_WIDTH-1:0] root_reg, root_next;

    always_comb begin
        logic [udd_pkg::SUM_WIDTH-1:0]   p_rad;
        logic [udd_pkg::SQ_REM_W-1:0]    p_rem;
        logic [udd_pkg::DIST_WIDTH-1:0]  p_root;
        logic [udd_pkg::SQ_REM_W+1:0]    cur;
        logic [udd_pkg::SQ_REM_W+1:0]    trial;
        for (int k = 0; k < udd_pkg::SQ_STAGES; k++) begin
            if (k == 0) begin
                p_rad  = rad_in;
                p_rem  = '0;
                p_root = '0;
            end else begin
                p_rad  = rad_reg[k-1];
                p_rem  = rem_reg[k-1];
                p_root = root_reg[k-1];
            end
            cur   = {p_rem, p_rad[udd_pkg::SUM_WIDTH-1 -: 2]};
            trial = {1'b0, p_root, 2'b01};
            rad_next[k] = {p_rad[udd_pkg::SUM_WIDTH-3:0], 2'b00};
            if (cur >= trial) begin
                rem_next[k]  = udd_pkg::SQ_REM_W'(cur - trial);
                root_next[k] = {p_root[udd_pkg::DIST_WIDTH-2:0], 1'b1};
            end else begin
                rem_next[k]  = cur[udd_pkg::SQ_REM_W-1:0];
                root_next[k] = {p_root[udd_pkg::DIST_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg[udd_pkg::SQ_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/udd_div_lane.sv
// One divider lane: restoring division of mag * 2^15 by the distance,
// one quotient bit per stage. Depends on udd_pkg.
`default_nettype none

module udd_div_lane (
    input  wire logic                                                   aclk,
    input  wire logic                                                   en,
    input  wire logic [udd_pkg::MAG_WIDTH-1:0]                          mag_in,
    input  wire logic [udd_pkg::DIV_STAGES-1:0][udd_pkg::DIST_WIDTH-1:0] dvs,
    output logic      [udd_pkg::UNIT_WIDTH-1:0]                         quot_out
);

    logic [udd_pkg::DIV_STAGES-1:0][udd_pkg::DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [udd_pkg::DIV_STAGES-1:0][udd_pkg::UNIT_WIDTH-1:0] q_reg,   q_next;

    always_comb begin
        logic [udd_pkg::DIV_REM_W-1:0]  p_rem;
        logic [udd_pkg::UNIT_WIDTH-1:0] p_q;
        logic [udd_pkg::DIV_REM_W-1:0]  d;
        logic [udd_pkg::DIV_REM_W-1:0]  r;
        for (int j = 0; j < udd_pkg::DIV_STAGES; j++) begin
            if (j == 0) begin
                p_rem = udd_pkg::DIV_REM_W'(mag_in);
                p_q   = '0;
            end else begin
                p_rem = rem_reg[j-1];
                p_q   = q_reg[j-1];
            end
            d = {1'b0, dvs[j]};
            if (p_rem >= d) begin
                r         = p_rem - d;
                q_next[j] = {p_q[udd_pkg::UNIT_WIDTH-2:0], 1'b1};
            end else begin
                r         = p_rem;
                q_next[j] = {p_q[udd_pkg::UNIT_WIDTH-2:0], 1'b0};
            end
            // r < d here, so the shift cannot overflow
            rem_next[j] = {r[udd_pkg::DIV_REM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quot_out = q_reg[udd_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/unit_direction_and_distance_top.sv
// Top level: difference, squares, square root, three divider lanes, merge.
// Depends on udd_pkg, udd_sqrt, udd_div_lane.
//
// Usage:
//   s_ channel: one beat carries points A and B (signed Q12.12 coordinates).
//   m_ channel: one beat per input beat, in order: distance (Q12, floored),
//     unit vector in Q1.15 (truncated toward zero, +1.0 saturates to 32767)
//     and zero_length when A equals B (unit components then forced to 0).
//   cfg channel: writes three_dimensional (always ready). In 2D mode z is
//     ignored and unit_z is 0. Write only while the block is idle.
// Throughput: one beat per cycle while m_ready keeps up; a full skid register holds s_ready low.
// Pipeline: 3 front stages, 25 square-root stages of one bit each, 16
//   divider stages of one quotient bit each, then the output register.
// Stall: the output register is backed by a one-entry skid register; the
//   pipeline advances while the skid is empty, so s_ready drops once a new
//   result lands in the skid while m_ready stalls the output, and nothing is lost.
// Reset (aresetn low, synchronous): pipeline and output empty,
//   three_dimensional = 1.
`default_nettype none

module unit_direction_and_distance_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_ax,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_ay,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_az,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_bx,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_by,
    input  wire logic signed [udd_pkg::COORD_WIDTH-1:0] s_bz,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic        [udd_pkg::DIST_WIDTH-1:0]  m_distance,
    output logic signed [udd_pkg::UNIT_WIDTH-1:0]  m_unit_x,
    output logic signed [udd_pkg::UNIT_WIDTH-1:0]  m_unit_y,
    output logic signed [udd_pkg::UNIT_WIDTH-1:0]  m_unit_z,
    output logic                                   m_zero_length
);

    localparam int NL = udd_pkg::NUM_LANES;

    typedef struct packed {
        logic [udd_pkg::DIST_WIDTH-1:0]  distance;
        logic [udd_pkg::UNIT_WIDTH-1:0]  ux;
        logic [udd_pkg::UNIT_WIDTH-1:0]  uy;
        logic [udd_pkg::UNIT_WIDTH-1:0]  uz;
        logic                            zero;
    } res_t;

    // config
    logic use_z_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_z_reg <= 1'b1;
        end else if (cfg_valid) begin
            use_z_reg <= cfg_data;
        end
    end

    // pipeline control: all stages move together while the skid is empty
    logic                             adv;
    logic [udd_pkg::PIPE_STAGES-1:0]  vld_reg;
    logic                             skid_vld_reg;
    logic                             out_vld_reg;
    res_t                             out_reg, skid_reg, res_new;

    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[udd_pkg::PIPE_STAGES-2:0], s_valid};
        end
    end

    // stage 0: differences, signs and magnitudes
    udd_pkg::side_t side_in;
    udd_pkg::side_t side_reg [udd_pkg::PIPE_STAGES];

    always_comb begin
        logic signed [udd_pkg::DIFF_WIDTH-1:0] d [NL];
        d[0] = udd_pkg::DIFF_WIDTH'(s_bx) - udd_pkg::DIFF_WIDTH'(s_ax);
        d[1] = udd_pkg::DIFF_WIDTH'(s_by) - udd_pkg::DIFF_WIDTH'(s_ay);
        d[2] = use_z_reg ? udd_pkg::DIFF_WIDTH'(s_bz) - udd_pkg::DIFF_WIDTH'(s_az) : '0;
        side_in.use_z = use_z_reg;
        for (int i = 0; i < NL; i++) begin
            side_in.neg[i] = d[i][udd_pkg::DIFF_WIDTH-1];
            side_in.mag[i] = d[i][udd_pkg::DIFF_WIDTH-1] ? udd_pkg::MAG_WIDTH'(-d[i])
                                                        : udd_pkg::MAG_WIDTH'(d[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < udd_pkg::PIPE_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 1: squares, stage 2: sum
    logic [NL-1:0][udd_pkg::SQ_WIDTH-1:0] sq_reg;
    logic [udd_pkg::SUM_WIDTH-1:0]        sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NL; i++) begin
                sq_reg[i] <= udd_pkg::SQ_WIDTH'(side_reg[0].mag[i] * side_reg[0].mag[i]);
            end
            sum_reg <= udd_pkg::SUM_WIDTH'(sq_reg[0]) + udd_pkg::SUM_WIDTH'(sq_reg[1])
                     + udd_pkg::SUM_WIDTH'(sq_reg[2]);
        end
    end

    // square root
    logic [udd_pkg::DIST_WIDTH-1:0] root;

    udd_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .rad_in   (sum_reg),
        .root_out (root)
    );

    // distance follows the divider stages
    logic [udd_pkg::DIV_STAGES-1:0][udd_pkg::DIST_WIDTH-1:0] dist_reg;
    logic [udd_pkg::DIV_STAGES-1:0][udd_pkg::DIST_WIDTH-1:0] dvs;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg[0] <= root;
            for (int j = 1; j < udd_pkg::DIV_STAGES; j++) begin
                dist_reg[j] <= dist_reg[j-1];
            end
        end
    end

    always_comb begin
        dvs[0] = root;
        for (int j = 1; j < udd_pkg::DIV_STAGES; j++) begin
            dvs[j] = dist_reg[j-1];
        end
    end

    // divider lanes
    logic [NL-1:0][udd_pkg::UNIT_WIDTH-1:0] quot;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        udd_div_lane u_lane (
            .aclk     (aclk),
            .en       (adv),
            .mag_in   (side_reg[udd_pkg::SQ_LAST].mag[g]),
            .dvs      (dvs),
            .quot_out (quot[g])
        );
    end

    // merge: signs, saturation, zero length
    udd_pkg::side_t side_last;
    logic [udd_pkg::DIST_WIDTH-1:0] dist_last;
    assign side_last = side_reg[udd_pkg::PIPE_STAGES-1];
    assign dist_last = dist_reg[udd_pkg::DIV_STAGES-1];

    always_comb begin
        logic [NL-1:0][udd_pkg::UNIT_WIDTH-1:0] u;
        logic                                   zero;
        zero = (dist_last == '0);
        for (int i = 0; i < NL; i++) begin
            if (zero) begin
                u[i] = '0;
            end else if (side_last.neg[i]) begin
                u[i] = -quot[i];          // quotient at most 2^15
            end else if (quot[i][udd_pkg::UNIT_WIDTH-1]) begin
                u[i] = udd_pkg::UNIT_MAX;
            end else begin
                u[i] = quot[i];
            end
        end
        res_new.distance = dist_last;
        res_new.ux       = u[0];
        res_new.uy       = u[1];
        res_new.uz       = side_last.use_z ? u[2] : '0;
        res_new.zero     = zero;
    end

    // output register with skid
    logic new_beat;
    assign new_beat = adv && vld_reg[udd_pkg::PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (skid_vld_reg) begin
                if (m_ready) begin
                    out_reg      <= skid_reg;
                    skid_vld_reg <= 1'b0;
                end
            end else if (new_beat) begin
                if (!out_vld_reg || m_ready) begin
                    out_reg     <= res_new;
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_reg     <= res_new;
                    skid_vld_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_distance    = out_reg.distance;
    assign m_unit_x      = out_reg.ux;
    assign m_unit_y      = out_reg.uy;
    assign m_unit_z      = out_reg.uz;
    assign m_zero_length = out_reg.zero;

endmodule

`default_nettype wire

FILE: bench/udd_checker.sv
// Checker for the unit direction and distance block: watches s_, m_ and cfg beats,
// predicts each result and compares it in order. Depends on udd_pkg.
module udd_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic                                  cfg_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic signed [udd_pkg::COORD_WIDTH-1:0] s_ax, s_ay, s_az, s_bx, s_by, s_bz,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [udd_pkg::DIST_WIDTH-1:0]        m_distance,
    input  logic signed [udd_pkg::UNIT_WIDTH-1:0] m_unit_x, m_unit_y, m_unit_z,
    input  logic                                  m_zero_length,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import udd_pkg::*;

    typedef struct packed {
        logic [DIST_WIDTH-1:0]        span;
        logic signed [UNIT_WIDTH-1:0] ux, uy, uz;
        logic                         zl;
    } dir_t;

    dir_t dir_q[$];
    logic use_z;

    function automatic logic [UNIT_WIDTH-1:0] unit_of(longint d, longint len);
        longint mag, q;
        mag = d < 0 ? -d : d;
        q = (mag <<< UNIT_FRAC) / len;
        if (d < 0) return (-q < -32768) ? 16'h8000 : 16'(-q);
        return (q > 32767) ? UNIT_MAX : 16'(q);
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r, b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'sd1 <<< i);
            if (b * b <= n) r = b;
        end
        return r;
    endfunction

    function automatic dir_t predict_dir(logic z);
        dir_t e;
        longint dx, dy, dz, len;
        dx = longint'(s_bx) - longint'(s_ax);
        dy = longint'(s_by) - longint'(s_ay);
        dz = z ? longint'(s_bz) - longint'(s_az) : 0;
        len = floor_sqrt(dx * dx + dy * dy + dz * dz);
        e.span = len[DIST_WIDTH-1:0];
        e.zl = (len == 0);
        e.ux = e.zl ? '0 : unit_of(dx, len);
        e.uy = e.zl ? '0 : unit_of(dy, len);
        e.uz = (e.zl || !z) ? '0 : unit_of(dz, len);
        return e;
    endfunction

    always @(posedge aclk) begin
        dir_t e;
        if (!aresetn) begin
            use_z <= 1'b1;
            fail_count <= 0;
            zero_seen <= 0;
            dir_q.delete();
        end else begin
            if (s_valid && s_ready) dir_q.push_back(predict_dir(use_z));
            if (cfg_valid && cfg_ready) use_z <= cfg_data;
            if (m_valid && m_ready) begin
                if (dir_q.size() == 0) begin
                    $display("%0t: unexpected result beat", $time);
                    fail_count <= fail_count + 1;
                end else begin
                    e = dir_q.pop_front();
                    if (m_zero_length) zero_seen <= zero_seen + 1;
                    if (e != {m_distance, m_unit_x, m_unit_y, m_unit_z, m_zero_length}) begin
                        $display("%0t: mismatch exp d=%0d u=(%0d,%0d,%0d) z=%0b",
                                 $time, e.span, e.ux, e.uy, e.uz, e.zl);
                        $display("%0t:          act d=%0d u=(%0d,%0d,%0d) z=%0b",
                                 $time, m_distance, m_unit_x, m_unit_y, m_unit_z,
                                 m_zero_length);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = dir_q.size();
endmodule

FILE: bench/tb_unit_direction_and_distance_top.sv
// Testbench top: clock, reset, stimulus for points and config, and the verdict.
// Depends on udd_pkg, udd_checker and the unit_direction_and_distance_top RTL.
module tb_unit_direction_and_distance_top;
    timeunit 1ns;
    timeprecision 1ps;
    import udd_pkg::*;

    localparam int LATENCY = 45;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0, cfg_data = 1'b0, cfg_ready;
    logic s_valid = 1'b0, s_ready;
    logic signed [COORD_WIDTH-1:0] s_ax = '0, s_ay = '0, s_az = '0;
    logic signed [COORD_WIDTH-1:0] s_bx = '0, s_by = '0, s_bz = '0;
    logic m_valid, m_ready = 1'b0;
    logic [DIST_WIDTH-1:0] m_distance;
    logic signed [UNIT_WIDTH-1:0] m_unit_x, m_unit_y, m_unit_z;
    logic m_zero_length;
    int fail_count, pending, zero_seen;
    int beats_sent;
    bit calm;   // no idling on either side while set

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    unit_direction_and_distance_top u_top (.*);
    udd_checker u_chk (.*);

    // Sink: stalls about 31% of cycles unless in the calm stretch.
    always @(negedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 31);

    // Corner coordinates: extremes, zero and near-zero, small values, else fully random.
    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            3: return 24'($urandom_range(8)) - 24'd4;
            4: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Drive one point pair, hold until accepted; optional idle first.
    // Valid stays up after the beat so the next pair can follow directly.
    task automatic send_pair(logic [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        {s_ax, s_ay, s_az, s_bx, s_by, s_bz} <= {ax, ay, az, bx, by, bz};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic random_pair();
        logic [COORD_WIDTH-1:0] ax, ay, az;
        ax = pick_coord(); ay = pick_coord(); az = pick_coord();
        case ($urandom_range(5))
            0: send_pair(ax, ay, az, ax, ay, az);                   // equal points
            1: send_pair(ax, ay, az, pick_coord(), ay, az);          // pure x axis
            2: send_pair(ax, ay, az, ax + 24'($urandom_range(7)) - 24'd3,
                         ay + 24'($urandom_range(7)) - 24'd3, az);   // tiny vector
            default: send_pair(ax, ay, az, pick_coord(), pick_coord(), pick_coord());
        endcase
    endtask

    // Wait for the pipe to drain before touching the register.
    task automatic drain_and_write(logic v);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        calm = 1'b0;
        beats_sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset 3D mode, extremes, axis directions, equal points.
        send_pair('0, '0, '0, '0, '0, '0);
        send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
        send_pair('0, '0, '0, 24'd4096, '0, '0);          // +1.0 on x saturates
        send_pair('0, '0, '0, 24'hFFF000, '0, '0);        // -1.0 on x is exact
        send_pair('0, '0, '0, '0, 24'd1, '0);
        send_pair('0, '0, '0, '0, '0, 24'hFFFFFF);
        send_pair(24'h800000, '0, '0, 24'h7FFFFF, '0, '0);
        send_pair('0, '0, 24'h123456, '0, '0, 24'h123456);
        send_pair(24'd3, 24'd4, '0, '0, '0, '0);
        drain_and_write(1'b0);
        // 2D: z, where it differs, must be ignored
        send_pair('0, '0, 24'h800000, '0, '0, 24'h7FFFFF);
        send_pair('0, '0, '0, 24'd7, 24'hFFFFF9, 24'd99);
        send_pair(24'h800000, 24'h7FFFFF, '0, 24'h7FFFFF, 24'h800000, '0);
        send_pair('0, '0, '0, '0, 24'h800000, 24'h555555);
        drain_and_write(1'b1);

        // Random: phases alternate 3D and 2D, one calm stretch in the middle.
        for (int phase = 0; phase < 6; phase++) begin
            calm = (phase == 2);
            for (int i = 0; i < 272; i++) random_pair();
            drain_and_write(phase[0] ? 1'b1 : 1'b0);
        end
        calm = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        $display("Sent %0d point pairs over 3D and 2D phases; %0d zero-length results.",
                 beats_sent, zero_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: ends the run as failed if the stimulus has not finished by then.
    initial begin
        #(12ns * 1000000);
        $display("TEST FAILED");
        $finish;
    end
endmodule
